// ===== rtl/bw2d_pkg.sv =====
// package for the barycentric weights core
// widths and the shared payload types, no dependencies
package bw2d_pkg;
    localparam int CoordBits = 16;
    localparam int FracBits  = 16;
    localparam int DiffBits  = CoordBits + 1;
    localparam int ProdBits  = 2 * DiffBits;
    localparam int CrossBits = ProdBits + 1;
    localparam int MagBits   = CrossBits - 1;
    localparam int NumBits   = CrossBits + FracBits;
    localparam int QuoBits   = NumBits;

    typedef struct packed {
        logic signed [CoordBits-1:0] point_x;
        logic signed [CoordBits-1:0] point_y;
        logic signed [CoordBits-1:0] first_x;
        logic signed [CoordBits-1:0] first_y;
        logic signed [CoordBits-1:0] second_x;
        logic signed [CoordBits-1:0] second_y;
        logic signed [CoordBits-1:0] third_x;
        logic signed [CoordBits-1:0] third_y;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] weight_first;
        logic signed [31:0] weight_second;
        logic signed [31:0] weight_third;
        logic               degenerate;
    } t_out_word;
endpackage

// ===== rtl/bw2d_if.sv =====
// valid/ready channel carrying one payload word
// depends on bw2d_pkg for the word types
interface bw2d_in_if;
    logic               valid;
    logic               ready;
    bw2d_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bw2d_out_if;
    logic                valid;
    logic                ready;
    bw2d_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/barycentric_weights_2d_core.sv =====
// barycentric weights of a point in a 2d triangle, fully pipelined
// depends on bw2d_pkg and the channel interfaces in bw2d_if.sv
//
//  channel   dir  word
//  i_in      in   point, first, second, third vertex (x, y), 16b signed
//  o_out     out  weight_first/second/third 32b signed, degenerate
//
// one word per cycle sustained while the output is not stalled; 6 + NumBits
// (57) register stages, most of them the restoring divider that retires one
// quotient bit per stage for both weights. reset (i_rst_n, synchronous) clears
// the valid bits only. a stall at the output freezes the whole pipe (common
// enable), so nothing is lost.
module barycentric_weights_2d_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bw2d_in_if.sink           i_in,
    bw2d_out_if.source        o_out
);
    localparam int DB = bw2d_pkg::DiffBits;
    localparam int PB = bw2d_pkg::ProdBits;
    localparam int XB = bw2d_pkg::CrossBits;
    localparam int MB = bw2d_pkg::MagBits;
    localparam int NB = bw2d_pkg::NumBits;
    localparam int FB = bw2d_pkg::FracBits;
    localparam int QB = bw2d_pkg::QuoBits;

    // whole pipe moves when the output stage is empty or drained
    logic w_adv;
    assign w_adv = !o_out.valid || o_out.ready;
    assign i_in.ready = w_adv;

    // stage 1: differences
    logic                 r_v1;
    logic signed [DB-1:0] r_d1x, r_d1y, r_d3x, r_d3y, r_pbx, r_pby;
    logic signed [DB-1:0] r_pcx, r_pcy, r_acx, r_acy;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_adv) r_v1 <= i_in.valid;
        if (w_adv) begin
            r_d1x <= DB'(i_in.data.first_x) - DB'(i_in.data.second_x);
            r_d1y <= DB'(i_in.data.first_y) - DB'(i_in.data.second_y);
            r_d3x <= DB'(i_in.data.third_x) - DB'(i_in.data.second_x);
            r_d3y <= DB'(i_in.data.third_y) - DB'(i_in.data.second_y);
            r_pbx <= DB'(i_in.data.point_x) - DB'(i_in.data.second_x);
            r_pby <= DB'(i_in.data.point_y) - DB'(i_in.data.second_y);
            r_pcx <= DB'(i_in.data.point_x) - DB'(i_in.data.third_x);
            r_pcy <= DB'(i_in.data.point_y) - DB'(i_in.data.third_y);
            r_acx <= DB'(i_in.data.first_x) - DB'(i_in.data.third_x);
            r_acy <= DB'(i_in.data.first_y) - DB'(i_in.data.third_y);
        end
    end

    // stage 2: products, one multiplier each
    logic                 r_v2;
    logic signed [PB-1:0] r_s0, r_s1, r_a0, r_a1, r_b0, r_b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_adv) r_v2 <= r_v1;
        if (w_adv) begin
            r_s0 <= r_d1x * r_d3y;
            r_s1 <= r_d1y * r_d3x;
            r_a0 <= r_pbx * r_d3y;
            r_a1 <= r_pby * r_d3x;
            r_b0 <= r_pcx * r_acy;
            r_b1 <= r_pcy * r_acx;
        end
    end

    // stage 3: cross products
    logic                 r_v3;
    logic signed [XB-1:0] r_s, r_na, r_nb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (w_adv) r_v3 <= r_v2;
        if (w_adv) begin
            r_s  <= XB'(r_s0) - XB'(r_s1);
            r_na <= XB'(r_a0) - XB'(r_a1);
            r_nb <= XB'(r_b0) - XB'(r_b1);
        end
    end

    // stage 4: magnitudes and signs; dividend is |num| << frac bits
    typedef struct packed {
        logic          neg_a;
        logic          neg_b;
        logic          degen;
        logic [MB-1:0] den;
        logic [NB-1:0] num_a;
        logic [NB-1:0] num_b;
        logic [MB:0]   rem_a;
        logic [MB:0]   rem_b;
    } t_div;

    logic r_v4;
    t_div r_d4;
    logic [XB-1:0] w_ms, w_ma, w_mb;
    assign w_ms = r_s[XB-1]  ? -r_s  : r_s;
    assign w_ma = r_na[XB-1] ? -r_na : r_na;
    assign w_mb = r_nb[XB-1] ? -r_nb : r_nb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (w_adv) r_v4 <= r_v3;
        if (w_adv) begin
            r_d4.neg_a <= r_na[XB-1] ^ r_s[XB-1];
            r_d4.neg_b <= r_nb[XB-1] ^ r_s[XB-1];
            r_d4.degen <= (r_s == '0);
            r_d4.den   <= w_ms[MB-1:0];
            r_d4.num_a <= {w_ma, {FB{1'b0}}};
            r_d4.num_b <= {w_mb, {FB{1'b0}}};
            r_d4.rem_a <= '0;
            r_d4.rem_b <= '0;
        end
    end

    // divider: one restoring step per stage, quotient shifts into num
    logic [QB:0] r_vq;
    t_div        r_q [QB+1];
    always_comb r_q[0] = r_d4;
    assign r_vq[0] = r_v4;
    genvar g;
    generate
        for (g = 0; g < QB; g++) begin : g_div
            logic [MB+1:0] w_ta, w_tb, w_sa, w_sb;
            t_div          n_q;
            always_comb begin
                n_q  = r_q[g];
                w_ta = {r_q[g].rem_a, r_q[g].num_a[NB-1]};
                w_tb = {r_q[g].rem_b, r_q[g].num_b[NB-1]};
                w_sa = w_ta - {2'b00, r_q[g].den};
                w_sb = w_tb - {2'b00, r_q[g].den};
                n_q.rem_a = w_sa[MB+1] ? w_ta[MB:0] : w_sa[MB:0];
                n_q.rem_b = w_sb[MB+1] ? w_tb[MB:0] : w_sb[MB:0];
                n_q.num_a = {r_q[g].num_a[NB-2:0], ~w_sa[MB+1]};
                n_q.num_b = {r_q[g].num_b[NB-2:0], ~w_sb[MB+1]};
            end
            logic r_vs;
            t_div r_qs;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) r_vs <= 1'b0;
                else if (w_adv) r_vs <= r_vq[g];
                if (w_adv) r_qs <= n_q;
            end
            assign r_vq[g+1] = r_vs;
            always_comb r_q[g+1] = r_qs;
        end
    endgenerate

    // saturate magnitudes then apply sign
    function automatic logic signed [33:0] sat_w(input logic [NB-1:0] mag,
                                               input logic neg);
        logic signed [33:0] res;
        begin
            if (neg) res = (mag > NB'(64'h8000_0000)) ? -34'sh8000_0000
                                                      : -$signed({1'b0, mag[32:0]});
            else     res = (mag > NB'(64'h7fff_ffff)) ? 34'sh7fff_ffff
                                                      : $signed({1'b0, mag[32:0]});
            return res;
        end
    endfunction

    logic               r_v5;
    logic signed [33:0] r_wa, r_wb;
    logic               r_dg5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (w_adv) r_v5 <= r_vq[QB];
        if (w_adv) begin
            r_dg5 <= r_q[QB].degen;
            r_wa  <= r_q[QB].degen ? '0 : sat_w(r_q[QB].num_a, r_q[QB].neg_a);
            r_wb  <= r_q[QB].degen ? '0 : sat_w(r_q[QB].num_b, r_q[QB].neg_b);
        end
    end

    // third weight and output register
    logic signed [33:0] w_wc;
    logic signed [31:0] w_wcs;
    assign w_wc  = (34'sd1 <<< FB) - r_wa - r_wb;
    assign w_wcs = r_dg5 ? 32'sd0
                 : (w_wc > 34'sh7fff_ffff) ? 32'sh7fff_ffff
                 : (w_wc < -34'sh8000_0000) ? -32'sh8000_0000 : w_wc[31:0];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_out.valid <= 1'b0;
        else if (w_adv) o_out.valid <= r_v5;
        if (w_adv) begin
            o_out.data.weight_first  <= r_wa[31:0];
            o_out.data.weight_second <= r_wb[31:0];
            o_out.data.weight_third  <= w_wcs;
            o_out.data.degenerate    <= r_dg5;
        end
    end
endmodule

// ===== verif/bw2d_tb_files.sv =====
`timescale 1ns / 1ps
// predictor and result scoreboard for the barycentric weights core testbench
// depends on bw2d_pkg for the word types
class bw2d_weight_board;
    bw2d_pkg::t_out_word pending_q[$];
    int unsigned         errors;

    function new();
        pending_q = {};
        errors    = 0;
    endfunction

    // fixed-point ratio, truncated toward zero, saturated to 32 bits
    static function longint weight_ratio(longint num, longint den);
        longint unsigned n, d, q, r, frac, mag;
        bit neg;
        longint res;
        neg  = (num < 0) != (den < 0);
        n    = num < 0 ? -num : num;
        d    = den < 0 ? -den : den;
        q    = n / d;
        r    = n % d;
        frac = 0;
        for (int i = 0; i < bw2d_pkg::FracBits; i++) begin
            r    = r << 1;
            frac = frac << 1;
            if (r >= d) begin
                r    = r - d;
                frac = frac | 1;
            end
        end
        if (q > (64'd1 << 32)) q = 64'd1 << 32;
        mag = (q << bw2d_pkg::FracBits) | frac;
        res = neg ? -longint'(mag) : longint'(mag);
        return sat_weight(res);
    endfunction

    static function longint sat_weight(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    static function longint cross_2d(longint ux, longint uy, longint wx, longint wy);
        return ux * wy - uy * wx;
    endfunction

    // note an accepted input word and queue its expected weights
    function void note_input(bw2d_pkg::t_in_word w);
        bw2d_pkg::t_out_word e;
        longint px, py, ax, ay, bx, by, cx, cy, area, wa, wb, wc;
        px = w.point_x;  py = w.point_y;
        ax = w.first_x;  ay = w.first_y;
        bx = w.second_x; by = w.second_y;
        cx = w.third_x;  cy = w.third_y;
        area = cross_2d(ax - bx, ay - by, cx - bx, cy - by);
        wa = 0; wb = 0; wc = 0;
        e.degenerate = (area == 0);
        if (area != 0) begin
            wa = weight_ratio(cross_2d(px - bx, py - by, cx - bx, cy - by), area);
            wb = weight_ratio(cross_2d(px - cx, py - cy, ax - cx, ay - cy), area);
            wc = sat_weight((64'sd1 <<< bw2d_pkg::FracBits) - wa - wb);
        end
        e.weight_first  = wa[31:0];
        e.weight_second = wb[31:0];
        e.weight_third  = wc[31:0];
        pending_q.push_back(e);
    endfunction

    // compare a result word with the oldest expectation
    function void check_result(bw2d_pkg::t_out_word got);
        bw2d_pkg::t_out_word e;
        if (pending_q.size() == 0) begin
            $display("%0t unexpected result: got %p", $time, got);
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (got.weight_first !== e.weight_first) begin
            $display("%0t weight_first: expected %0d actual %0d",
                     $time, e.weight_first, got.weight_first);
            errors++;
        end
        if (got.weight_second !== e.weight_second) begin
            $display("%0t weight_second: expected %0d actual %0d",
                     $time, e.weight_second, got.weight_second);
            errors++;
        end
        if (got.weight_third !== e.weight_third) begin
            $display("%0t weight_third: expected %0d actual %0d",
                     $time, e.weight_third, got.weight_third);
            errors++;
        end
        if (got.degenerate !== e.degenerate) begin
            $display("%0t degenerate: expected %0b actual %0b",
                     $time, e.degenerate, got.degenerate);
            errors++;
        end
    endfunction
endclass

// ===== verif/barycentric_weights_2d_core_tb.sv =====
`timescale 1ns / 1ps
// testbench top for barycentric_weights_2d_core: directed and random words
// depends on bw2d_pkg, bw2d_if.sv and the weight board in bw2d_tb_files.sv
module barycentric_weights_2d_core_tb;
    localparam int Latency  = 6 + bw2d_pkg::NumBits;
    localparam int IdleLimit = 20000;
    localparam int CB = bw2d_pkg::CoordBits;

    logic i_clk;
    logic i_rst_n;
    bw2d_in_if  in_ch ();
    bw2d_out_if out_ch ();

    barycentric_weights_2d_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    bw2d_weight_board board;
    int send_idle_pct;   // chance per cycle the sender holds off
    int recv_stall_pct;  // chance per cycle the receiver stalls
    int idle_cycles;
    bit timed_out;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
        end
    end

    // receiver ready, redrawn at each falling edge
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with nothing accepted on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    // offer one word and hold it until accepted; valid stays high afterwards
    task automatic send_word(bw2d_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(5))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($urandom_range(64)) - 32;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic bw2d_pkg::t_in_word make_tri(int px, int py, int ax, int ay,
                                                    int bx, int by, int cx, int cy);
        bw2d_pkg::t_in_word w;
        w.point_x  = CB'(px); w.point_y  = CB'(py);
        w.first_x  = CB'(ax); w.first_y  = CB'(ay);
        w.second_x = CB'(bx); w.second_y = CB'(by);
        w.third_x  = CB'(cx); w.third_y  = CB'(cy);
        return w;
    endfunction

    // small triangles with a point near them, else random or collinear words
    function automatic bw2d_pkg::t_in_word rand_word();
        bw2d_pkg::t_in_word w;
        int kind, ox, oy, sz;
        kind = $urandom_range(9);
        if (kind < 3) begin
            w = bw2d_pkg::t_in_word'({$urandom, $urandom, $urandom, $urandom});
        end else if (kind < 5) begin
            w = make_tri(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end else if (kind == 5) begin
            // collinear vertices, random point
            ox = int'($signed(16'($urandom))); oy = int'($signed(16'($urandom)));
            sz = $urandom_range(1, 200);
            w = make_tri($urandom, $urandom, ox, oy, ox + sz, oy + 2 * sz,
                         ox - sz, oy - 2 * sz);
        end else begin
            ox = int'($signed(16'($urandom))) / 2;
            oy = int'($signed(16'($urandom))) / 2;
            sz = $urandom_range(1, 4000);
            w = make_tri(ox + $signed($urandom_range(2 * sz)) - sz,
                         oy + $signed($urandom_range(2 * sz)) - sz,
                         ox + $signed($urandom_range(sz)), oy,
                         ox, oy + $signed($urandom_range(sz)),
                         ox - $signed($urandom_range(sz)),
                         oy - $signed($urandom_range(sz)));
        end
        return w;
    endfunction

    // drop valid and wait for every expected result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, vertices, interior point, degenerate, saturation
        send_word(make_tri(0, 0, 0, 0, 16, 0, 0, 16));
        send_word(make_tri(16, 0, 0, 0, 16, 0, 0, 16));
        send_word(make_tri(0, 16, 0, 0, 16, 0, 0, 16));
        send_word(make_tri(5, 5, 0, 0, 16, 0, 0, 16));
        send_word(make_tri(1, 1, 0, 0, 0, 0, 0, 0));
        send_word(make_tri(7, 9, 1, 1, 2, 2, 3, 3));
        send_word(make_tri(-32768, -32768, 0, 0, 1, 0, 0, 1));
        send_word(make_tri(32767, 32767, 0, 0, 1, 0, 0, 1));
        send_word(make_tri(32767, -32768, 0, 0, 1, 0, 0, 1));
        send_word(make_tri(0, 0, -32768, -32768, 32767, -32768, -32768, 32767));
        send_word(make_tri(32767, 32767, -32768, -32768, 32767, -32768,
                           -32768, 32767));
        send_word(make_tri(-32768, 32767, 32767, 32767, -32768, -32768,
                           32767, -32768));
        send_word(make_tri(0, 0, 0, 0, 0, 16, 16, 0));
        send_word(make_tri(-1, -1, -1, -1, -1, -1, -1, -1));
        send_word(make_tri(32767, 32767, 32767, 32767, 32767, 32767,
                           32767, 32767));
        send_word(make_tri(-32768, -32768, -32768, -32768, -32768, -32768,
                           -32768, -32768));
        send_word(make_tri(3, 0, 0, 0, 0, 1, 1, 0));
        send_word(make_tri(-20, 13, 5, 7, -3, 11, 2, -9));
        // hold off until everything has come back
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            repeat (150) send_word(rand_word());
        end

        recv_stall_pct = 0;
        drain();
        repeat (Latency + 10) @(negedge i_clk);
        if (board.errors == 0 && board.pending_q.size() == 0 && !out_ch.valid)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/bw2d_pkg.sv
rtl/bw2d_if.sv
rtl/barycentric_weights_2d_core.sv
verif/bw2d_tb_files.sv
verif/barycentric_weights_2d_core_tb.sv
